>>> design/ohlc_bar_aggregator_assert.svh
// Assertion macros for the OHLC bar aggregator.
`ifndef OHLC_BAR_AGGREGATOR_ASSERT_SVH
`define OHLC_BAR_AGGREGATOR_ASSERT_SVH
`ifndef SYNTH
`define OBA_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define OBA_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define OBA_ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define OBA_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

>>> design/oba_pkg.sv
// Shared types and constants of the OHLC bar aggregator.
`timescale 1ns / 1ps
package oba_pkg;
    localparam int INSTRUMENTS_DEF = 64;
    localparam int PRICE_WIDTH_DEF = 32;
    localparam int TS_W = 48;
    localparam int VOL_W = 48;
    localparam int CNT_W = 32;
    localparam int PER_W = 27;
    localparam int ID_W = 6;
    localparam logic [PER_W-1:0] PERIOD_RESET = 27'd60000;

    typedef struct packed {
        logic [5:0]  instrument_id;
        logic [47:0] timestamp_ms;
        logic signed [31:0] price;
        logic [31:0] volume;
    } t_tick;

    typedef struct packed {
        logic [5:0]  bar_instrument;
        logic [47:0] bar_start_ms;
        logic signed [31:0] bar_open;
        logic signed [31:0] bar_high;
        logic signed [31:0] bar_low;
        logic signed [31:0] bar_close;
        logic [47:0] bar_volume;
        logic [31:0] bar_ticks;
    } t_bar;

    typedef enum logic [1:0] {
        ST_IDLE, ST_DIV, ST_DONE
    } t_div_state;

    typedef enum logic [1:0] {
        ST_WAIT, ST_READ, ST_UPDATE
    } t_back_state;
endpackage

>>> design/oba_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module oba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> design/oba_front.sv
// Front end: accept ticks, compute bucket start with a serial divider.
`timescale 1ns / 1ps
module oba_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  oba_pkg::t_tick         i_tick,
    input  logic [oba_pkg::PER_W-1:0] i_period,
    output logic                   o_valid,
    input  logic                   i_stall,
    output oba_pkg::t_tick         o_tick,
    output logic [oba_pkg::TS_W-1:0] o_start
);
    localparam int TS_W = oba_pkg::TS_W;
    localparam int PER_W = oba_pkg::PER_W;
    localparam int CW = $clog2(TS_W);

    oba_pkg::t_div_state r_state, n_state;
    oba_pkg::t_tick r_tick;
    logic [TS_W-1:0] r_quo;
    logic [PER_W:0]  r_rem;
    logic [PER_W-1:0] r_per;
    logic [CW-1:0]   r_cnt;
    logic [PER_W+1:0] w_trial;
    logic [PER_W:0]  w_shift;
    logic            w_acc;

    assign w_acc = i_valid && !o_stall;
    // restoring divide, one quotient bit per cycle
    assign w_shift = {r_rem[PER_W-1:0], r_quo[TS_W-1]};
    assign w_trial = {1'b0, w_shift} - {2'b0, r_per};

    always_comb begin
        n_state = r_state;
        case (r_state)
            oba_pkg::ST_IDLE: if (w_acc) n_state = oba_pkg::ST_DIV;
            oba_pkg::ST_DIV:  if (r_cnt == CW'(TS_W-1)) n_state = oba_pkg::ST_DONE;
            oba_pkg::ST_DONE: if (!i_stall) n_state = oba_pkg::ST_IDLE;
            default: n_state = oba_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            oba_pkg::ST_IDLE: o_stall = 1'b0;
            oba_pkg::ST_DONE: o_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oba_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (w_acc) begin
            r_tick <= i_tick;
            r_quo  <= i_tick.timestamp_ms;
            r_rem  <= '0;
            r_per  <= (i_period == '0) ? PER_W'(1) : i_period;
            r_cnt  <= '0;
        end else if (r_state == oba_pkg::ST_DIV) begin
            r_cnt <= r_cnt + CW'(1);
            if (!w_trial[PER_W+1]) begin
                r_rem <= w_trial[PER_W:0];
                r_quo <= {r_quo[TS_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[TS_W-2:0], 1'b0};
            end
        end
    end

    assign o_tick = r_tick;
    // start = ts - remainder
    assign o_start = r_tick.timestamp_ms - TS_W'(r_rem);
endmodule

>>> design/oba_queue.sv
// Two-entry queue between front and back.
`timescale 1ns / 1ps
module oba_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_d0, r_d1;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data = r_d0;
    assign w_push = i_valid && !o_stall;
    assign w_pop = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_pop) begin
            r_d0 <= (r_cnt == 2'd2) ? r_d1 : i_data;
        end else if (w_push && r_cnt == 2'd0) begin
            r_d0 <= i_data;
        end
        if (w_push && ((r_cnt == 2'd1 && !w_pop) || r_cnt == 2'd2)) begin
            r_d1 <= i_data;
        end
    end
endmodule

>>> design/oba_back.sv
// Back end: per-instrument read-modify-write of the open bar.
`timescale 1ns / 1ps
module oba_back #(
    parameter int INSTRUMENTS = oba_pkg::INSTRUMENTS_DEF,
    parameter int PRICE_WIDTH = oba_pkg::PRICE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  oba_pkg::t_tick           i_tick,
    input  logic [oba_pkg::TS_W-1:0] i_start,
    output logic                     o_valid,
    input  logic                     i_stall,
    output oba_pkg::t_bar            o_bar
);
    localparam int AW = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;
    localparam int TS_W = oba_pkg::TS_W;
    localparam int VOL_W = oba_pkg::VOL_W;
    localparam int CNT_W = oba_pkg::CNT_W;
    localparam int PW = PRICE_WIDTH;
    localparam int RW = TS_W + 4 * PW + VOL_W + CNT_W;

    oba_pkg::t_back_state r_state, n_state;
    logic [INSTRUMENTS-1:0] r_open;
    logic [AW-1:0] w_addr;
    logic w_inrange, w_we, w_emit;
    logic [RW-1:0] w_rd, w_wd;
    logic [TS_W-1:0] w_st;
    logic signed [PW-1:0] w_fi, w_hi, w_lo, w_la, w_p;
    logic [VOL_W-1:0] w_vo;
    logic [VOL_W:0] w_sum;
    logic [CNT_W-1:0] w_rc;
    logic [CNT_W-1:0] w_c;
    logic w_new;
    oba_pkg::t_bar r_bar;
    logic r_obv;

    assign w_addr = AW'(i_tick.instrument_id);
    assign w_inrange = ({26'b0, i_tick.instrument_id} < 32'(INSTRUMENTS));
    assign w_p = PW'(i_tick.price);
    assign {w_st, w_fi, w_hi, w_lo, w_la, w_vo, w_rc} = w_rd;
    assign w_c = r_open[w_addr] ? w_rc : '0;
    assign w_new = (w_c == '0) || (w_st != i_start);
    assign w_sum = {1'b0, w_vo} + {17'b0, i_tick.volume};

    oba_ram #(.WIDTH(RW), .DEPTH(INSTRUMENTS)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_addr), .i_wdata(w_wd),
        .i_raddr(w_addr), .o_rdata(w_rd)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            oba_pkg::ST_WAIT: if (i_valid) n_state = w_inrange ? oba_pkg::ST_READ
                                                            : oba_pkg::ST_UPDATE;
            oba_pkg::ST_READ: n_state = oba_pkg::ST_UPDATE;
            oba_pkg::ST_UPDATE: if (!(r_obv && i_stall)) n_state = oba_pkg::ST_WAIT;
            default: n_state = oba_pkg::ST_WAIT;
        endcase
    end

    always_comb begin
        w_we = 1'b0;
        o_stall = 1'b1;
        w_emit = 1'b0;
        w_wd = '0;
        case (r_state)
            oba_pkg::ST_UPDATE: begin
                // pop only when the output register is free
                if (!(r_obv && i_stall)) begin
                    o_stall = 1'b0;
                    if (w_inrange) begin
                        w_we = 1'b1;
                        w_emit = w_new && (w_c != '0);
                    end
                end
                if (w_new) begin
                    w_wd = {i_start, w_p, w_p, w_p, w_p, VOL_W'(i_tick.volume),
                            CNT_W'(1)};
                end else begin
                    w_wd = {w_st, w_fi, (w_p > w_hi) ? w_p : w_hi,
                            (w_p < w_lo) ? w_p : w_lo, w_p,
                            w_sum[VOL_W] ? {VOL_W{1'b1}} : w_sum[VOL_W-1:0],
                            (w_c == {CNT_W{1'b1}}) ? w_c : w_c + CNT_W'(1)};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oba_pkg::ST_WAIT;
            r_open <= '0;
            r_obv <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_we) begin
                r_open[w_addr] <= 1'b1;
            end
            if (w_emit) begin
                r_obv <= 1'b1;
            end else if (!i_stall) begin
                r_obv <= 1'b0;
            end
        end
        if (w_emit) begin
            r_bar.bar_instrument <= i_tick.instrument_id;
            r_bar.bar_start_ms <= w_st;
            r_bar.bar_open <= 32'($unsigned(w_fi));
            r_bar.bar_high <= 32'($unsigned(w_hi));
            r_bar.bar_low <= 32'($unsigned(w_lo));
            r_bar.bar_close <= 32'($unsigned(w_la));
            r_bar.bar_volume <= w_vo;
            r_bar.bar_ticks <= w_c;
        end
    end

    assign o_valid = r_obv;
    assign o_bar = r_bar;
endmodule

>>> design/ohlc_bar_aggregator.sv
// Top level of the OHLC bar aggregator.
// Usage:
//  Tick words enter on i_valid/o_stall with payload i_tick; finished bars
//  leave on o_valid/i_stall with payload o_bar. The bar period register
//  is written on i_cfg_valid/o_cfg_ready (always ready); write it only while
//  idle, which the block itself does not enforce. In the front end a
//  restoring divider yields one quotient bit per cycle over the 48-bit
//  timestamp, then hands the word on. The back end reads the instrument's
//  bar from a RAM and writes it back through its read and update states.
//  A two-word queue sits between them; the front end takes a new tick only
//  once it has handed on the last one. A bar is loaded into the output
//  register by the back end's update of its closing tick. Reset clears all
//  bars (open flags in flip-flops) and sets the period to 60000 ms. When the
//  receiver stalls, the bar holds in the output register and the back end
//  holds its next update; the queue then fills and o_stall rises.
`timescale 1ns / 1ps
`include "ohlc_bar_aggregator_assert.svh"
module ohlc_bar_aggregator #(
    parameter int INSTRUMENTS = oba_pkg::INSTRUMENTS_DEF,
    parameter int PRICE_WIDTH = oba_pkg::PRICE_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  oba_pkg::t_tick i_tick,
    output logic           o_valid,
    input  logic           i_stall,
    output oba_pkg::t_bar  o_bar,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [oba_pkg::PER_W-1:0] i_cfg_data
);
    localparam int QW = $bits(oba_pkg::t_tick) + oba_pkg::TS_W;
    logic [oba_pkg::PER_W-1:0] r_period;
    logic f_valid, f_stall, q_valid, q_stall;
    oba_pkg::t_tick f_tick, q_tick;
    logic [oba_pkg::TS_W-1:0] f_start, q_start;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= oba_pkg::PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_period <= i_cfg_data;
        end
    end

    oba_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_tick(i_tick), .i_period(r_period), .o_valid(f_valid),
        .i_stall(f_stall), .o_tick(f_tick), .o_start(f_start)
    );

    oba_queue #(.WIDTH(QW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid), .o_stall(f_stall),
        .i_data({f_tick, f_start}), .o_valid(q_valid), .i_stall(q_stall),
        .o_data({q_tick, q_start})
    );

    oba_back #(.INSTRUMENTS(INSTRUMENTS), .PRICE_WIDTH(PRICE_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_stall(q_stall),
        .i_tick(q_tick), .i_start(q_start), .o_valid(o_valid),
        .i_stall(i_stall), .o_bar(o_bar)
    );

    `OBA_ASSERT_NEXT(a_bar_holds, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_bar))
    `OBA_ASSERT_IMPL(a_ticks_nonzero, i_clk, i_rst_n, o_valid, o_bar.bar_ticks != 32'd0)
    `OBA_ASSERT_IMPL(a_bar_order, i_clk, i_rst_n, o_valid, o_bar.bar_low <= o_bar.bar_high)
endmodule

>>> verif/ohlc_bar_checker.sv
// Checker for the OHLC bar aggregator: predicts finished bars and compares them.
`timescale 1ns / 1ps
module ohlc_bar_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_stall_in,
    input  oba_pkg::t_tick            i_tick,
    input  logic                      i_bar_valid,
    input  logic                      i_bar_stall,
    input  oba_pkg::t_bar             i_bar,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [oba_pkg::PER_W-1:0] i_cfg_data,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_bars_seen
);
    localparam logic [47:0] VOL_SAT = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] CNT_SAT = 32'hFFFF_FFFF;

    logic [oba_pkg::PER_W-1:0] period_q;
    logic [47:0]        bar_start [64];
    logic signed [31:0] bar_open [64];
    logic signed [31:0] bar_hi [64];
    logic signed [31:0] bar_lo [64];
    logic signed [31:0] bar_last [64];
    logic [47:0]        bar_vol [64];
    logic [31:0]        bar_cnt [64];
    oba_pkg::t_bar      bars_due [$];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    task automatic fold_tick(input oba_pkg::t_tick t);
        logic [47:0] per;
        logic [47:0] start;
        logic [48:0] vsum;
        oba_pkg::t_bar b;
        int k;
        k = t.instrument_id;
        per = (period_q == '0) ? 48'd1 : {21'd0, period_q};
        start = t.timestamp_ms - (t.timestamp_ms % per);
        if (bar_cnt[k] == 0 || bar_start[k] != start) begin
            if (bar_cnt[k] != 0) begin
                b.bar_instrument = t.instrument_id;
                b.bar_start_ms = bar_start[k];
                b.bar_open = bar_open[k];
                b.bar_high = bar_hi[k];
                b.bar_low = bar_lo[k];
                b.bar_close = bar_last[k];
                b.bar_volume = bar_vol[k];
                b.bar_ticks = bar_cnt[k];
                bars_due.insert(bars_due.size(), b);
            end
            bar_start[k] = start;
            bar_open[k] = t.price;
            bar_hi[k] = t.price;
            bar_lo[k] = t.price;
            bar_last[k] = t.price;
            bar_vol[k] = {16'd0, t.volume};
            bar_cnt[k] = 32'd1;
        end else begin
            if (t.price > bar_hi[k]) bar_hi[k] = t.price;
            if (t.price < bar_lo[k]) bar_lo[k] = t.price;
            bar_last[k] = t.price;
            vsum = {1'b0, bar_vol[k]} + {17'd0, t.volume};
            bar_vol[k] = vsum[48] ? VOL_SAT : vsum[47:0];
            if (bar_cnt[k] != CNT_SAT) bar_cnt[k] = bar_cnt[k] + 32'd1;
        end
    endtask

    task automatic compare_bar(input oba_pkg::t_bar got);
        oba_pkg::t_bar want;
        if (bars_due.size() == 0) begin
            report("unexpected bar", 64'(got.bar_instrument), 64'd0);
            return;
        end
        want = bars_due.pop_front();
        if (got.bar_instrument != want.bar_instrument)
            report("instrument", 64'(got.bar_instrument), 64'(want.bar_instrument));
        if (got.bar_start_ms != want.bar_start_ms)
            report("start", 64'(got.bar_start_ms), 64'(want.bar_start_ms));
        if (got.bar_open != want.bar_open)
            report("open", 64'(unsigned'(got.bar_open)), 64'(unsigned'(want.bar_open)));
        if (got.bar_high != want.bar_high)
            report("high", 64'(unsigned'(got.bar_high)), 64'(unsigned'(want.bar_high)));
        if (got.bar_low != want.bar_low)
            report("low", 64'(unsigned'(got.bar_low)), 64'(unsigned'(want.bar_low)));
        if (got.bar_close != want.bar_close)
            report("close", 64'(unsigned'(got.bar_close)), 64'(unsigned'(want.bar_close)));
        if (got.bar_volume != want.bar_volume)
            report("volume", 64'(got.bar_volume), 64'(want.bar_volume));
        if (got.bar_ticks != want.bar_ticks)
            report("ticks", 64'(got.bar_ticks), 64'(want.bar_ticks));
    endtask

    initial begin
        o_errors = 0;
        o_bars_seen = 0;
        o_pending = 0;
        period_q = oba_pkg::PERIOD_RESET;
        for (int i = 0; i < 64; i++) bar_cnt[i] = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_bar_valid && !i_bar_stall) begin
                compare_bar(i_bar);
                o_bars_seen++;
            end
            if (i_valid && !i_stall_in) fold_tick(i_tick);
            if (i_cfg_valid && i_cfg_ready) period_q = i_cfg_data;
            o_pending = bars_due.size();
        end
    end

    final begin
        if (bars_due.size() != 0) $display("leftover expected bars: %0d", bars_due.size());
    end
endmodule

>>> verif/ohlc_bar_aggregator_test.sv
// Testbench top for the OHLC bar aggregator: stimulus, reset and verdict.
`timescale 1ns / 1ps
module ohlc_bar_aggregator_test;
    localparam longint CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 120;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_stall;
    oba_pkg::t_tick   i_tick = '0;
    logic             o_valid;
    logic             i_stall = 1'b0;
    oba_pkg::t_bar    o_bar;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [oba_pkg::PER_W-1:0] i_cfg_data = '0;
    int               errors;
    int               pending;
    int               bars_seen;
    int               ticks_sent = 0;
    int               periods_used = 0;
    longint           cycles = 0;
    logic [47:0]      clock_ms [64];

    ohlc_bar_aggregator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_tick(i_tick),
        .o_valid(o_valid), .i_stall(i_stall), .o_bar(o_bar),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    ohlc_bar_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall_in(o_stall), .i_tick(i_tick),
        .i_bar_valid(o_valid), .i_bar_stall(i_stall), .i_bar(o_bar),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_bars_seen(bars_seen)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // random receiver stall: a random hold drawn per bar, with quiet stretches
    initial begin
        int hold;
        forever begin
            @(negedge i_clk);
            if (o_valid && !i_stall) begin
                hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                if (hold != 0) begin
                    i_stall <= 1'b1;
                    repeat (hold) @(negedge i_clk);
                    i_stall <= 1'b0;
                end
            end else begin
                i_stall <= ($urandom_range(0, 7) == 0);
            end
        end
    end

    task automatic send_tick(input oba_pkg::t_tick t);
        int gap;
        gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 12);
        repeat (gap) @(negedge i_clk);
        i_tick <= t;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        i_valid <= 1'b0;
        ticks_sent++;
    endtask

    task automatic write_period(input logic [oba_pkg::PER_W-1:0] value);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        periods_used++;
    endtask

    function automatic oba_pkg::t_tick make_tick(input logic [5:0] id, input logic [47:0] ts,
                                                 input logic [31:0] px,
                                                 input logic [31:0] vol);
        oba_pkg::t_tick t;
        t.instrument_id = id;
        t.timestamp_ms = ts;
        t.price = px;
        t.volume = vol;
        return t;
    endfunction

    // mostly well-formed: few instruments, time moving forward within and across bars
    task automatic random_phase(input int count, input logic [oba_pkg::PER_W-1:0] per);
        logic [5:0]  id;
        logic [47:0] step;
        logic [47:0] ts;
        int pick;
        for (int n = 0; n < count; n++) begin
            id = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
            pick = $urandom_range(0, 9);
            if (pick < 6) step = 48'($urandom_range(0, 2)) * 48'(per) / 3;
            else if (pick < 8) step = 48'(per) * 48'($urandom_range(1, 3));
            else step = 48'(per) * 48'($urandom_range(0, 1000)) + 48'($urandom);
            ts = clock_ms[id] + step;
            if (pick == 9 && $urandom_range(0, 1)) ts = 48'({$urandom, $urandom}); // jump anywhere
            clock_ms[id] = ts;
            send_tick(make_tick(id, ts, $urandom,
                ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom));
        end
    endtask

    initial begin
        for (int i = 0; i < 64; i++) clock_ms[i] = 48'($urandom) << 8;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: default period, price and volume extremes, earlier bucket
        send_tick(make_tick(6'd0, 48'd0, 32'h8000_0000, 32'd0));
        send_tick(make_tick(6'd0, 48'd59999, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_tick(make_tick(6'd0, 48'd30000, 32'hFFFF_FFFF, 32'd1));
        send_tick(make_tick(6'd0, 48'd60000, 32'd0, 32'd5));
        send_tick(make_tick(6'd0, 48'd0, 32'd7, 32'd5));
        send_tick(make_tick(6'd63, 48'hFFFF_FFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
        send_tick(make_tick(6'd63, 48'hFFFF_FFFF_FFF0, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_tick(make_tick(6'd63, 48'd1, 32'd1, 32'd1));
        send_tick(make_tick(6'd0, 48'd0, 32'd1, 32'd1));

        // zero period behaves as one
        write_period('0);
        send_tick(make_tick(6'd5, 48'd100, 32'd3, 32'd3));
        send_tick(make_tick(6'd5, 48'd100, 32'd4, 32'd3));
        send_tick(make_tick(6'd5, 48'd101, 32'd2, 32'd3));
        send_tick(make_tick(6'd5, 48'd101, 32'd2, 32'd3));
        // period above the nominal range, then the largest field value
        write_period(27'd100_000_000);
        send_tick(make_tick(6'd9, 48'd99_999_999, 32'd1, 32'd1));
        send_tick(make_tick(6'd9, 48'd100_000_000, 32'd2, 32'd1));
        write_period(27'h7FF_FFFF);
        send_tick(make_tick(6'd9, 48'h7FF_FFFE, 32'd1, 32'd1));
        send_tick(make_tick(6'd9, 48'h7FF_FFFF, 32'd2, 32'd1));
        send_tick(make_tick(6'd9, 48'd0, 32'd2, 32'd1));

        // random phases over several periods
        write_period(27'd60000);
        random_phase(250, 27'd60000);
        write_period(27'd5000);
        random_phase(250, 27'd5000);
        write_period(27'd1);
        random_phase(150, 27'd1);
        write_period(27'd86_400_000);
        random_phase(200, 27'd86_400_000);
        write_period(27'($urandom_range(2, 999)));
        random_phase(250, 27'd500);

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("sent %0d ticks over %0d period settings, checked %0d bars",
                 ticks_sent, periods_used + 1, bars_seen);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
